### design/tsif_pkg.sv
// Shared types and constants for the thresholded spectral inverse filter.
package tsif_pkg;

   localparam int unsigned CsrIndexWidth = 8;
   localparam logic [CsrIndexWidth-1:0] CsrOtfNorm       = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBandThreshold = 8'd1;
   localparam logic [31:0] OtfNormReset       = 32'h0001_0000;
   localparam logic [31:0] BandThresholdReset = 32'h0000_0000;
   localparam int unsigned QuotBits = 32;

   // Payload travelling through the divider stages.
   typedef struct packed {
      logic [63:0] denom;
      logic [63:0] rem_re;
      logic [63:0] rem_im;
      logic [31:0] low_re;
      logic [31:0] low_im;
      logic [31:0] quot_re;
      logic [31:0] quot_im;
      logic        big_re;
      logic        big_im;
      logic        neg_re;
      logic        neg_im;
      logic        in_band;
      logic        last;
   } div_type;

endpackage

### design/tsif_if.sv
// Channel interfaces: bin requests, results and register writes.
interface tsif_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] image_re;
   logic signed [31:0] image_im;
   logic signed [31:0] otf_re;
   logic signed [31:0] otf_im;
   logic               last_bin;
   modport source (output valid, image_re, image_im, otf_re, otf_im, last_bin, input ready);
   modport sink   (input valid, image_re, image_im, otf_re, otf_im, last_bin, output ready);
endinterface

interface tsif_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_re;
   logic signed [31:0] result_im;
   logic               in_band;
   logic               saturated;
   logic               last_out;
   modport source (output valid, result_re, result_im, in_band, saturated, last_out,
                   input ready);
   modport sink   (input valid, result_re, result_im, in_band, saturated, last_out,
                   output ready);
endinterface

interface tsif_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### design/tsif_front.sv
// Front stages: products, power, threshold test, norm scaling, overflow check.
module tsif_front
   import tsif_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [31:0] image_re,
   input  logic signed [31:0] image_im,
   input  logic signed [31:0] otf_re,
   input  logic signed [31:0] otf_im,
   input  logic               last_bin,
   input  logic [31:0]        otf_norm,
   input  logic [31:0]        band_threshold,
   output logic               out_valid,
   output div_type            out_data
);
   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   // stage 1
   logic signed [63:0] prr_ff, pii_ff, pa_ff, pb_ff, pc_ff, pd_ff;
   logic [63:0] lim1_ff;
   logic [31:0] n1_ff;
   logic        last1_ff;
   logic [31:0] n_eff;

   // stage 2
   logic signed [65:0] sum_re, sum_im;
   logic [63:0] s2_ff, mag_re2_ff, mag_im2_ff;
   logic        neg_re2_ff, neg_im2_ff, inb2_ff, last2_ff;
   logic [31:0] n2_ff;

   // stage 3
   logic [63:0] hre3_ff, lre3_ff, him3_ff, lim3_ff, s3_ff;
   logic        neg_re3_ff, neg_im3_ff, inb3_ff, last3_ff;

   // stage 4
   logic [95:0] dre4_ff, dim4_ff;
   logic [63:0] s4_ff;
   logic        neg_re4_ff, neg_im4_ff, inb4_ff, last4_ff;

   div_type out_ff;

   assign n_eff    = (otf_norm == 32'd0) ? 32'd1 : otf_norm;
   assign valid_in = {valid_ff[3:0], in_valid};
   assign sum_re   = 66'(pa_ff) + 66'(pb_ff);
   assign sum_im   = 66'(pc_ff) - 66'(pd_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prr_ff   <= otf_re * otf_re;
         pii_ff   <= otf_im * otf_im;
         pa_ff    <= image_re * otf_re;
         pb_ff    <= image_im * otf_im;
         pc_ff    <= image_im * otf_re;
         pd_ff    <= image_re * otf_im;
         lim1_ff  <= {32'd0, band_threshold} * {32'd0, n_eff};
         n1_ff    <= n_eff;
         last1_ff <= last_bin;

         s2_ff      <= $unsigned(prr_ff) + $unsigned(pii_ff);
         inb2_ff    <= ($unsigned(prr_ff) + $unsigned(pii_ff)) > lim1_ff;
         neg_re2_ff <= sum_re[65];
         neg_im2_ff <= sum_im[65];
         mag_re2_ff <= sum_re[65] ? 64'(-sum_re) : sum_re[63:0];
         mag_im2_ff <= sum_im[65] ? 64'(-sum_im) : sum_im[63:0];
         n2_ff      <= n1_ff;
         last2_ff   <= last1_ff;

         hre3_ff    <= {32'd0, mag_re2_ff[63:32]} * {32'd0, n2_ff};
         lre3_ff    <= {32'd0, mag_re2_ff[31:0]} * {32'd0, n2_ff};
         him3_ff    <= {32'd0, mag_im2_ff[63:32]} * {32'd0, n2_ff};
         lim3_ff    <= {32'd0, mag_im2_ff[31:0]} * {32'd0, n2_ff};
         s3_ff      <= s2_ff;
         neg_re3_ff <= neg_re2_ff;
         neg_im3_ff <= neg_im2_ff;
         inb3_ff    <= inb2_ff;
         last3_ff   <= last2_ff;

         dre4_ff    <= {hre3_ff, 32'd0} + {32'd0, lre3_ff};
         dim4_ff    <= {him3_ff, 32'd0} + {32'd0, lim3_ff};
         s4_ff      <= s3_ff;
         neg_re4_ff <= neg_re3_ff;
         neg_im4_ff <= neg_im3_ff;
         inb4_ff    <= inb3_ff;
         last4_ff   <= last3_ff;

         // quotient needs more than 32 bits iff the upper part reaches the divisor
         out_ff.denom   <= s4_ff;
         out_ff.rem_re  <= dre4_ff[95:32];
         out_ff.rem_im  <= dim4_ff[95:32];
         out_ff.low_re  <= dre4_ff[31:0];
         out_ff.low_im  <= dim4_ff[31:0];
         out_ff.quot_re <= '0;
         out_ff.quot_im <= '0;
         out_ff.big_re  <= dre4_ff[95:32] >= s4_ff;
         out_ff.big_im  <= dim4_ff[95:32] >= s4_ff;
         out_ff.neg_re  <= neg_re4_ff;
         out_ff.neg_im  <= neg_im4_ff;
         out_ff.in_band <= inb4_ff;
         out_ff.last    <= last4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = out_ff;
endmodule

### design/tsif_div_stage.sv
// One restoring division step for both result parts.
module tsif_div_stage
   import tsif_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    en,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);
   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic [64:0] trial_re, trial_im;
   logic        take_re, take_im;

   always_comb begin
      trial_re = {in_data.rem_re, in_data.low_re[31]};
      trial_im = {in_data.rem_im, in_data.low_im[31]};
      take_re  = trial_re >= {1'b0, in_data.denom};
      take_im  = trial_im >= {1'b0, in_data.denom};
      data_in  = in_data;
      data_in.rem_re  = take_re ? 64'(trial_re - {1'b0, in_data.denom}) : trial_re[63:0];
      data_in.rem_im  = take_im ? 64'(trial_im - {1'b0, in_data.denom}) : trial_im[63:0];
      data_in.low_re  = {in_data.low_re[30:0], 1'b0};
      data_in.low_im  = {in_data.low_im[30:0], 1'b0};
      data_in.quot_re = {in_data.quot_re[30:0], take_re};
      data_in.quot_im = {in_data.quot_im[30:0], take_im};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

### design/thresholded_spectral_inverse_filter_unit.sv
// Top level of the thresholded spectral inverse filter.
//
// req carries one image spectrum bin and the matching transfer function bin
// (signed Q16.16) with a last_bin marker; rsp returns the deconvolved bin,
// saturated to 32 bits, with in_band, saturated and last_out flags.
// csr writes otf_norm (index 0) and band_threshold (index 1); other indexes
// are dropped. Write registers only while no item is in flight.
// Throughput: one item per cycle unless rsp back-pressure stalls the pipe.
// From acceptance to rsp.valid an item passes five front stages (products,
// power and threshold, norm scaling, dividend assembly, overflow check), 32
// one-bit restoring divider stages and the saturating output register.
// Reset clears all valid bits and loads otf_norm = 1.0, band_threshold = 0.
// When rsp.ready is low with a result waiting, the whole pipeline holds and
// req.ready drops; nothing is lost or repeated.
module thresholded_spectral_inverse_filter_unit
   import tsif_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tsif_req_if.sink   req,
   tsif_rsp_if.source rsp,
   tsif_csr_if.sink   csr
);
   logic [31:0] otf_norm_ff, band_threshold_ff;
   logic        en;
   logic        front_valid;
   div_type     front_data;
   logic        stage_valid [QuotBits+1];
   div_type     stage_data  [QuotBits+1];

   logic        out_valid_ff;
   logic [31:0] res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic        inb_ff, sat_ff, last_ff, sat_in;
   logic        sat_re, sat_im;
   div_type     fin;

   assign en        = !out_valid_ff || rsp.ready;
   assign req.ready = en;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         otf_norm_ff       <= OtfNormReset;
         band_threshold_ff <= BandThresholdReset;
      end else if (csr.valid) begin
         case (csr.index)
            CsrOtfNorm:       otf_norm_ff       <= csr.data;
            CsrBandThreshold: band_threshold_ff <= csr.data;
            default: ;
         endcase
      end
   end

   tsif_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (req.valid),
      .image_re       (req.image_re),
      .image_im       (req.image_im),
      .otf_re         (req.otf_re),
      .otf_im         (req.otf_im),
      .last_bin       (req.last_bin),
      .otf_norm       (otf_norm_ff),
      .band_threshold (band_threshold_ff),
      .out_valid      (front_valid),
      .out_data       (front_data)
   );

   assign stage_valid[0] = front_valid;
   assign stage_data[0]  = front_data;

   for (genvar k = 0; k < QuotBits; k++) begin : g_div
      tsif_div_stage u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   always_comb begin
      fin    = stage_data[QuotBits];
      sat_re = fin.neg_re ? (fin.big_re || fin.quot_re > 32'h8000_0000)
                          : (fin.big_re || fin.quot_re[31]);
      sat_im = fin.neg_im ? (fin.big_im || fin.quot_im > 32'h8000_0000)
                          : (fin.big_im || fin.quot_im[31]);
      if (sat_re) begin
         res_re_in = fin.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         res_re_in = fin.neg_re ? 32'(32'd0 - fin.quot_re) : fin.quot_re;
      end
      if (sat_im) begin
         res_im_in = fin.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         res_im_in = fin.neg_im ? 32'(32'd0 - fin.quot_im) : fin.quot_im;
      end
      sat_in = sat_re || sat_im;
      if (!fin.in_band) begin
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= stage_valid[QuotBits];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         inb_ff    <= fin.in_band;
         sat_ff    <= sat_in;
         last_ff   <= fin.last;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.result_re = res_re_ff;
   assign rsp.result_im = res_im_ff;
   assign rsp.in_band   = inb_ff;
   assign rsp.saturated = sat_ff;
   assign rsp.last_out  = last_ff;
endmodule
